/* hw/rtl/b64e_pkg.sv */
// Package for the base64 line-wrapping encoder: shared types, constants
// and the sextet-to-character mapping. No dependencies.

package b64e_pkg;

    localparam int GROUPS_PER_LINE = 19;
    localparam int LINE_CNT_W      = 5;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QUEUE_PTR_W     = 1;
    localparam int QUEUE_CNT_W     = 2;
    localparam int CHAR_IDX_W      = 3;

    localparam logic [7:0] NEWLINE_CHAR = 8'd10;
    localparam logic [7:0] PAD_CHAR     = 8'd61;
    localparam logic [7:0] UPPER_BASE   = 8'd65;
    localparam logic [7:0] LOWER_BASE   = 8'd71;
    localparam logic [7:0] DIGIT_BASE   = 8'd4;
    localparam logic [7:0] PLUS_CHAR    = 8'd43;
    localparam logic [7:0] SLASH_CHAR   = 8'd47;

    // Bytes held in the current group
    localparam logic [1:0] POS_EMPTY = 2'd0;
    localparam logic [1:0] POS_ONE   = 2'd1;
    localparam logic [1:0] POS_TWO   = 2'd2;

    // Group lengths as queued for the back end
    localparam logic [1:0] LEN_ONE  = 2'd1;
    localparam logic [1:0] LEN_TWO  = 2'd2;
    localparam logic [1:0] LEN_FULL = 2'd3;

    // Character slots within one group job
    localparam logic [CHAR_IDX_W-1:0] SLOT_S0 = 3'd0;
    localparam logic [CHAR_IDX_W-1:0] SLOT_S1 = 3'd1;
    localparam logic [CHAR_IDX_W-1:0] SLOT_S2 = 3'd2;
    localparam logic [CHAR_IDX_W-1:0] SLOT_S3 = 3'd3;
    localparam logic [CHAR_IDX_W-1:0] SLOT_NL = 3'd4;

    typedef struct packed {
        logic [23:0] group;
        logic [1:0]  len;
        logic        newline;
        logic        last;
    } group_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26)
            return w + UPPER_BASE;
        else if (v < 6'd52)
            return w + LOWER_BASE;
        else if (v < 6'd62)
            return w - DIGIT_BASE;
        else if (v == 6'd62)
            return PLUS_CHAR;
        else
            return SLASH_CHAR;
    endfunction

endpackage

/* hw/rtl/b64e_ifs.sv */
// Valid/ready channel interfaces for the base64 encoder: raw bytes in,
// characters out. No dependencies.

interface b64e_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b64e_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       end_of_output;

    modport source (output valid, output out_char, output end_of_output, input ready);
    modport sink   (input valid, input out_char, input end_of_output, output ready);
endinterface

/* hw/rtl/b64e_queue.sv */
// Two-entry queue of group jobs between front and back end.
// Depends on b64e_pkg.

module b64e_queue
    import b64e_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  group_job_t    push_job,
    input  logic          pop,
    output group_job_t    head_job,
    output queue_status_t status
);

    group_job_t             mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   do_push, do_pop;

    assign status.full  = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_job     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

/* hw/rtl/b64e_front.sv */
// Front end: accepts raw bytes, collects groups of three, tracks the line
// position and queues one job per group. Depends on b64e_pkg, b64e_ifs.

module b64e_front
    import b64e_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    b64e_byte_if.sink     bytes,
    input  queue_status_t q_status,
    output logic          push,
    output group_job_t    push_job
);

    logic [15:0]           held_reg, held_next;
    logic [1:0]            pos_reg, pos_next;
    logic [LINE_CNT_W-1:0] line_cnt_reg, line_cnt_next;
    logic                  accept;
    logic [1:0]            pos;
    logic [LINE_CNT_W-1:0] line_inc;
    logic                  line_full;

    assign bytes.ready = !q_status.full;
    assign accept      = bytes.valid && bytes.ready;
    // A position of three cannot arise; treat it as an empty group
    assign pos         = (pos_reg == 2'd3) ? POS_EMPTY : pos_reg;
    assign line_inc    = line_cnt_reg + 1'b1;
    assign line_full   = (line_inc >= LINE_CNT_W'(GROUPS_PER_LINE));

    always_comb
    begin
        held_next     = held_reg;
        pos_next      = pos_reg;
        line_cnt_next = line_cnt_reg;
        push          = 1'b0;
        push_job      = '0;
        if (accept)
        begin
            if (pos != POS_TWO && !bytes.final_byte)
            begin
                // Hold the byte, nothing to emit yet
                if (pos == POS_EMPTY)
                    held_next = {bytes.data_byte, 8'h00};
                else
                    held_next = {held_reg[15:8], bytes.data_byte};
                pos_next = pos + 1'b1;
            end
            else
            begin
                push             = 1'b1;
                push_job.last    = bytes.final_byte;
                push_job.newline = 1'b0;
                case (pos)
                    POS_EMPTY:
                    begin
                        push_job.group = {bytes.data_byte, 16'h0000};
                        push_job.len   = LEN_ONE;
                    end
                    POS_ONE:
                    begin
                        push_job.group = {held_reg[15:8], bytes.data_byte, 8'h00};
                        push_job.len   = LEN_TWO;
                    end
                    default:
                    begin
                        push_job.group   = {held_reg, bytes.data_byte};
                        push_job.len     = LEN_FULL;
                        push_job.newline = line_full;
                        line_cnt_next    = line_full ? '0 : line_inc;
                    end
                endcase
                held_next = '0;
                pos_next  = POS_EMPTY;
                if (bytes.final_byte)
                    line_cnt_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg     <= '0;
            pos_reg      <= POS_EMPTY;
            line_cnt_reg <= '0;
        end
        else
        begin
            held_reg     <= held_next;
            pos_reg      <= pos_next;
            line_cnt_reg <= line_cnt_next;
        end
    end

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg != 2'd3)
        else $error("group position reached three");

    a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
        line_cnt_reg < LINE_CNT_W'(GROUPS_PER_LINE))
        else $error("line group count out of range");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("job pushed into a full queue");

endmodule

/* hw/rtl/b64e_back.sv */
// Back end: walks the head job, with padding and line break, into the output
// register one character per cycle when free. Depends on b64e_pkg, b64e_ifs.

module b64e_back
    import b64e_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  group_job_t    head_job,
    input  queue_status_t q_status,
    output logic          pop,
    b64e_char_if.source   chars
);

    logic [CHAR_IDX_W-1:0] idx_reg, idx_next;
    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            out_char_reg, out_char_next;
    logic                  out_end_reg, out_end_next;
    logic                  load, emit, is_end;
    logic [5:0]            s0, s1, s2, s3;
    logic [7:0]            ch;

    assign s0 = head_job.group[23:18];
    assign s1 = head_job.group[17:12];
    assign s2 = head_job.group[11:6];
    assign s3 = head_job.group[5:0];

    assign load   = !out_valid_reg || chars.ready;
    assign emit   = load && !q_status.empty;
    assign is_end = head_job.newline ? (idx_reg == SLOT_NL) : (idx_reg == SLOT_S3);
    assign pop    = emit && is_end;

    always_comb
    begin
        case (idx_reg)
            SLOT_S0: ch = sextet_char(s0);
            SLOT_S1: ch = sextet_char(s1);
            SLOT_S2: ch = (head_job.len == LEN_ONE) ? PAD_CHAR : sextet_char(s2);
            SLOT_S3: ch = (head_job.len == LEN_FULL) ? sextet_char(s3) : PAD_CHAR;
            default: ch = NEWLINE_CHAR;
        endcase
    end

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_end_next   = out_end_reg;
        if (load)
        begin
            out_valid_next = !q_status.empty;
            out_char_next  = ch;
            out_end_next   = head_job.last && is_end;
        end
        if (emit)
            idx_next = is_end ? SLOT_S0 : idx_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= SLOT_S0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_char_reg <= out_char_next;
        out_end_reg  <= out_end_next;
    end

    assign chars.valid         = out_valid_reg;
    assign chars.out_char      = out_char_reg;
    assign chars.end_of_output = out_end_reg;

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= SLOT_NL)
        else $error("character slot out of range");

    a_nl_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg == SLOT_NL) |-> (!q_status.empty && head_job.newline))
        else $error("newline slot without a newline job");

    a_mid_job: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != SLOT_S0) |-> !q_status.empty)
        else $error("job in progress with an empty queue");

endmodule

/* hw/rtl/base64_encoder_line_wrap.sv */
// Top level of the base64 encoder with 76-column line wrapping.
// Depends on b64e_pkg, b64e_ifs, b64e_front, b64e_queue, b64e_back.

// Raw bytes enter on the bytes channel, one per item, with final_byte set on
// the last byte of each message; base64 characters leave on the chars
// channel, one per item, with end_of_output on the last character of the
// message. The front end takes a byte every cycle while its two-entry job
// queue has room; the back end sends one character per cycle while the chars
// channel takes them and a job is queued, four characters per full group and
// a fifth at a line break. The first character of a group passes through the
// job queue and the output register after the byte that completes it is
// accepted. A line break follows every 19th full group; a message ending in
// a partial group is padded with '=' and gets no line break. The line count
// restarts with each message.

module base64_encoder_line_wrap
    import b64e_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    b64e_byte_if.sink   bytes,
    b64e_char_if.source chars
);

    logic          push, pop;
    group_job_t    push_job, head_job;
    queue_status_t q_status;

    b64e_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .bytes    (bytes),
        .q_status (q_status),
        .push     (push),
        .push_job (push_job)
    );

    b64e_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    b64e_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_job (head_job),
        .q_status (q_status),
        .pop      (pop),
        .chars    (chars)
    );

endmodule
